FILE: hdl/tlg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types, sizes and codes for the toroidal life grid with hue and age.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 32;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    localparam int FUNC_W     = 2;
    localparam int IN_ROW_W   = 3;
    localparam int IN_COL_W   = 5;
    localparam int HUE_W      = 8;
    localparam int CHG_W      = 9;
    localparam int NBR_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ROWS_W = 4;
    localparam int CFG_COLS_W = 6;

    localparam int ROW_CMP_W = (ROW_CNT_W > CFG_ROWS_W) ? ROW_CNT_W : CFG_ROWS_W;
    localparam int COL_CMP_W = (COL_CNT_W > CFG_COLS_W) ? COL_CNT_W : CFG_COLS_W;

    localparam logic [NBR_W-1:0] BIRTH_COUNT = NBR_W'(3);
    localparam logic [NBR_W-1:0] KEEP_COUNT  = NBR_W'(2);
    localparam int MIN_DIM = 3;

    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(8);
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(32);

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd2;

    typedef logic [MAX_COLS-1:0] grid_row_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [IN_ROW_W-1:0] row;
        logic [IN_COL_W-1:0] col;
        logic                alive_in;
    } cmd_t;

    typedef struct packed {
        logic             alive_out;
        logic [HUE_W-1:0] hue_out;
        logic [CHG_W-1:0] changed_count;
        logic             stable;
    } res_t;

    typedef struct packed {
        logic              row_re;
        logic [ROW_W-1:0]  row_raddr;
        logic              row_we;
        logic [ROW_W-1:0]  row_waddr;
        grid_row_t         row_wdata;
        logic              hue_re;
        logic              hue_we;
        logic [CELL_W-1:0] hue_addr;
        logic [HUE_W-1:0]  hue_wdata;
    } store_cmd_t;

    typedef struct packed {
        logic next_alive;
        logic changed;
        logic hue_we;
        logic hue_born;
    } cell_res_t;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return CELL_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tlg_cell_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_cell_unit
// Neighbor count and life rule for one cell of a three-row window.
// ----------------------------------------------------------------------------
module tlg_cell_unit
    import tlg_pkg::*;
(
    input  grid_row_t              up_row,
    input  grid_row_t              cur_row,
    input  grid_row_t              dn_row,
    input  logic [COL_W-1:0]       col,
    input  logic [COL_CNT_W-1:0]   ncols,
    output cell_res_t              res
);

    logic [COL_W-1:0] cm;
    logic [COL_W-1:0] cp;
    logic [COL_W-1:0] last_col;
    logic [NBR_W-1:0] nbrs;
    logic             alive;

    assign last_col = COL_W'(ncols - COL_CNT_W'(1));
    assign cm       = (col == '0) ? last_col : col - COL_W'(1);
    assign cp       = (col == last_col) ? '0 : col + COL_W'(1);
    assign alive    = cur_row[col];

    assign nbrs = NBR_W'(up_row[cm]) + NBR_W'(up_row[col]) + NBR_W'(up_row[cp])
                + NBR_W'(cur_row[cm]) + NBR_W'(cur_row[cp])
                + NBR_W'(dn_row[cm]) + NBR_W'(dn_row[col]) + NBR_W'(dn_row[cp]);

    always_comb
    begin
        res = '0;
        if (nbrs == BIRTH_COUNT)
        begin
            res.next_alive = 1'b1;
            res.hue_we     = !alive;
            res.hue_born   = 1'b1;
        end
        else if (nbrs == KEEP_COUNT)
        begin
            res.next_alive = alive;
        end
        else
        begin
            res.next_alive = 1'b0;
            res.hue_we     = 1'b1;
        end
        res.changed = res.next_alive != alive;
    end

endmodule
`default_nettype wire

FILE: hdl/tlg_grid_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_grid_store
// Row-wide alive memory and per-cell hue memory with reset valid bits.
// ----------------------------------------------------------------------------
module tlg_grid_store
    import tlg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_cmd_t       cmd,
    output grid_row_t        row_rdata,
    output logic [HUE_W-1:0] hue_rdata
);

    grid_row_t         row_mem [MAX_ROWS];
    logic [HUE_W-1:0]  hue_mem [CELLS];

    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [CELLS-1:0]    hue_vld_reg;
    grid_row_t           row_q_reg;
    logic                row_q_vld_reg;
    logic [HUE_W-1:0]    hue_q_reg;
    logic                hue_q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.row_we)
        begin
            row_mem[cmd.row_waddr] <= cmd.row_wdata;
        end
        if (cmd.row_re)
        begin
            row_q_reg <= row_mem[cmd.row_raddr];
        end
        if (cmd.hue_we)
        begin
            hue_mem[cmd.hue_addr] <= cmd.hue_wdata;
        end
        if (cmd.hue_re)
        begin
            hue_q_reg <= hue_mem[cmd.hue_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            hue_vld_reg   <= '0;
            row_q_vld_reg <= 1'b0;
            hue_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.row_we)
            begin
                row_vld_reg[cmd.row_waddr] <= 1'b1;
            end
            if (cmd.row_re)
            begin
                row_q_vld_reg <= row_vld_reg[cmd.row_raddr];
            end
            if (cmd.hue_we)
            begin
                hue_vld_reg[cmd.hue_addr] <= 1'b1;
            end
            if (cmd.hue_re)
            begin
                hue_q_vld_reg <= hue_vld_reg[cmd.hue_addr];
            end
        end
    end

    assign row_rdata = row_q_vld_reg ? row_q_reg : '0;
    assign hue_rdata = hue_q_vld_reg ? hue_q_reg : '0;

endmodule
`default_nettype wire

FILE: hdl/toroidal_life_grid_with_hue_age_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toroidal_life_grid_with_hue_age_core
// Toroidal life grid with per-cell hue, evaluated one cell per cycle along each row during a step.
// ----------------------------------------------------------------------------
// one cell rule evaluation per cycle along a row over a three-row window; one memory row
// read and one row write per cycle bound the row turnaround
// one transaction in flight; the next is taken once the result is registered
// reset: grid dead, hues zero, counter zero; no clearing pass is needed
module toroidal_life_grid_with_hue_age_core
    import tlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LD_RD     = 4'd1;
    localparam logic [3:0] S_LD_WR     = 4'd2;
    localparam logic [3:0] S_RD_RD     = 4'd3;
    localparam logic [3:0] S_RD_DATA   = 4'd4;
    localparam logic [3:0] S_G_START   = 4'd5;
    localparam logic [3:0] S_G_RD0     = 4'd6;
    localparam logic [3:0] S_G_RD1     = 4'd7;
    localparam logic [3:0] S_G_LOAD_DN = 4'd8;
    localparam logic [3:0] S_G_CELL    = 4'd9;
    localparam logic [3:0] S_G_ROW_END = 4'd10;
    localparam logic [3:0] S_FIN       = 4'd11;

    logic [3:0]            state_reg,    state_next;
    cmd_t                  req_reg,      req_next;
    res_t                  acc_reg,      acc_next;
    res_t                  out_reg,      out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HUE_W-1:0]      gen_reg,      gen_next;
    logic [HUE_W-1:0]      born_reg,     born_next;
    logic [CHG_W-1:0]      changed_reg,  changed_next;
    logic [ROW_W-1:0]      row_reg,      row_next;
    logic [COL_W-1:0]      col_reg,      col_next;
    grid_row_t             up_reg,       up_next;
    grid_row_t             cur_reg,      cur_next;
    grid_row_t             dn_reg,       dn_next;
    grid_row_t             row0_reg,     row0_next;
    grid_row_t             nrow_reg,     nrow_next;
    logic                  dn_wrap_reg,  dn_wrap_next;

    logic [HUE_W-1:0]      base_hue_reg;
    logic [CFG_ROWS_W-1:0] rows_used_reg;
    logic [CFG_COLS_W-1:0] cols_used_reg;

    logic [ROW_CNT_W-1:0]  nrows;
    logic [COL_CNT_W-1:0]  ncols;
    logic                  accept;
    logic                  cmd_inside;
    logic                  out_free;
    logic [ROW_W-1:0]      req_row;
    logic [COL_W-1:0]      req_col;
    logic [ROW_CNT_W-1:0]  row_p2;

    store_cmd_t            scmd;
    grid_row_t             row_rdata;
    logic [HUE_W-1:0]      hue_rdata;
    cell_res_t             rule_res;

    function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [CFG_ROWS_W-1:0] v);
        logic [ROW_CMP_W-1:0] x;
        x = ROW_CMP_W'(v);
        if (x < ROW_CMP_W'(MIN_DIM))
        begin
            x = ROW_CMP_W'(MIN_DIM);
        end
        if (x > ROW_CMP_W'(MAX_ROWS))
        begin
            x = ROW_CMP_W'(MAX_ROWS);
        end
        return ROW_CNT_W'(x);
    endfunction

    function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [CFG_COLS_W-1:0] v);
        logic [COL_CMP_W-1:0] x;
        x = COL_CMP_W'(v);
        if (x < COL_CMP_W'(MIN_DIM))
        begin
            x = COL_CMP_W'(MIN_DIM);
        end
        if (x > COL_CMP_W'(MAX_COLS))
        begin
            x = COL_CMP_W'(MAX_COLS);
        end
        return COL_CNT_W'(x);
    endfunction

    assign nrows      = clamp_rows(rows_used_reg);
    assign ncols      = clamp_cols(cols_used_reg);
    assign cmd_stall  = state_reg != S_IDLE;
    assign accept     = cmd_valid && !cmd_stall;
    assign cmd_inside = (ROW_CMP_W'(cmd.row) < ROW_CMP_W'(nrows))
                     && (COL_CMP_W'(cmd.col) < COL_CMP_W'(ncols));
    assign out_free   = !out_valid_reg || !res_stall;
    assign req_row    = ROW_W'(req_reg.row);
    assign req_col    = COL_W'(req_reg.col);
    assign row_p2     = ROW_CNT_W'(row_reg) + ROW_CNT_W'(2);

    assign cfg_ready  = 1'b1;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    tlg_grid_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (scmd),
        .row_rdata (row_rdata),
        .hue_rdata (hue_rdata)
    );

    tlg_cell_unit u_cell (
        .up_row  (up_reg),
        .cur_row (cur_reg),
        .dn_row  (dn_reg),
        .col     (col_reg),
        .ncols   (ncols),
        .res     (rule_res)
    );

    always_comb
    begin
        grid_row_t ld_row;
        state_next     = state_reg;
        req_next       = req_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        gen_next       = gen_reg;
        born_next      = born_reg;
        changed_next   = changed_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        up_next        = up_reg;
        cur_next       = cur_reg;
        dn_next        = dn_reg;
        row0_next      = row0_reg;
        nrow_next      = nrow_reg;
        dn_wrap_next   = dn_wrap_reg;
        scmd           = '0;
        ld_row         = row_rdata;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = cmd;
                    acc_next = '0;
                    case (cmd.func)
                        FUNC_LOAD:    state_next = cmd_inside ? S_LD_RD : S_FIN;
                        FUNC_STEP:    state_next = S_G_START;
                        FUNC_READ:    state_next = cmd_inside ? S_RD_RD : S_FIN;
                        FUNC_RESTART:
                        begin
                            gen_next   = base_hue_reg;
                            state_next = S_FIN;
                        end
                        default:      state_next = S_FIN;
                    endcase
                end
            end
            S_LD_RD:
            begin
                scmd.row_re    = 1'b1;
                scmd.row_raddr = req_row;
                state_next     = S_LD_WR;
            end
            S_LD_WR:
            begin
                ld_row[req_col] = req_reg.alive_in;
                scmd.row_we     = 1'b1;
                scmd.row_waddr  = req_row;
                scmd.row_wdata  = ld_row;
                scmd.hue_we     = 1'b1;
                scmd.hue_addr   = cell_addr(req_row, req_col);
                scmd.hue_wdata  = base_hue_reg;
                state_next      = S_FIN;
            end
            S_RD_RD:
            begin
                scmd.row_re    = 1'b1;
                scmd.row_raddr = req_row;
                scmd.hue_re    = 1'b1;
                scmd.hue_addr  = cell_addr(req_row, req_col);
                state_next     = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                acc_next.alive_out = row_rdata[req_col];
                acc_next.hue_out   = hue_rdata;
                state_next         = S_FIN;
            end
            S_G_START:
            begin
                scmd.row_re    = 1'b1;
                scmd.row_raddr = ROW_W'(nrows - ROW_CNT_W'(1));
                born_next      = base_hue_reg + gen_reg;
                changed_next   = '0;
                row_next       = '0;
                state_next     = S_G_RD0;
            end
            S_G_RD0:
            begin
                up_next        = row_rdata;
                scmd.row_re    = 1'b1;
                scmd.row_raddr = '0;
                state_next     = S_G_RD1;
            end
            S_G_RD1:
            begin
                cur_next       = row_rdata;
                row0_next      = row_rdata;
                nrow_next      = row_rdata;
                scmd.row_re    = 1'b1;
                scmd.row_raddr = ROW_W'(1);
                dn_wrap_next   = 1'b0;
                state_next     = S_G_LOAD_DN;
            end
            S_G_LOAD_DN:
            begin
                dn_next    = dn_wrap_reg ? row0_reg : row_rdata;
                col_next   = '0;
                state_next = S_G_CELL;
            end
            S_G_CELL:
            begin
                nrow_next[col_reg] = rule_res.next_alive;
                if (rule_res.changed && (changed_reg != '1))
                begin
                    changed_next = changed_reg + CHG_W'(1);
                end
                scmd.hue_we    = rule_res.hue_we;
                scmd.hue_addr  = cell_addr(row_reg, col_reg);
                scmd.hue_wdata = rule_res.hue_born ? born_reg : base_hue_reg;
                if (COL_CNT_W'(col_reg) == ncols - COL_CNT_W'(1))
                begin
                    state_next = S_G_ROW_END;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_G_ROW_END:
            begin
                scmd.row_we    = 1'b1;
                scmd.row_waddr = row_reg;
                scmd.row_wdata = nrow_reg;
                up_next        = cur_reg;
                cur_next       = dn_reg;
                nrow_next      = dn_reg;
                if (ROW_CNT_W'(row_reg) == nrows - ROW_CNT_W'(1))
                begin
                    acc_next.changed_count = changed_reg;
                    acc_next.stable        = changed_reg == '0;
                    gen_next               = gen_reg + HUE_W'(1);
                    state_next             = S_FIN;
                end
                else
                begin
                    row_next       = row_reg + ROW_W'(1);
                    dn_wrap_next   = row_p2 == nrows;
                    scmd.row_re    = row_p2 != nrows;
                    scmd.row_raddr = ROW_W'(row_p2);
                    state_next     = S_G_LOAD_DN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            gen_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            gen_reg       <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
        born_reg    <= born_next;
        changed_reg <= changed_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        up_reg      <= up_next;
        cur_reg     <= cur_next;
        dn_reg      <= dn_next;
        row0_reg    <= row0_next;
        nrow_reg    <= nrow_next;
        dn_wrap_reg <= dn_wrap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_hue_reg  <= '0;
            rows_used_reg <= ROWS_RESET;
            cols_used_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_HUE:  base_hue_reg  <= cfg_data;
                CFG_ROWS_USED: rows_used_reg <= cfg_data[CFG_ROWS_W-1:0];
                CFG_COLS_USED: cols_used_reg <= cfg_data[CFG_COLS_W-1:0];
                default:       ;
            endcase
        end
    end

    a_stable_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.stable || (res.changed_count == '0)))
        else $error("stable flag set with nonzero changed count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("transaction accepted without going busy");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_CELL) |-> (COL_CNT_W'(col_reg) < ncols))
        else $error("cell column outside used area");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G_CELL) |-> (ROW_CNT_W'(row_reg) < nrows))
        else $error("cell row outside used area");

endmodule
`default_nettype wire

FILE: sim/toroidal_life_grid_with_hue_age_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_with_hue_age_core_test
// Self-checking bench for the toroidal life grid core. A scoreboard keeps its
// own copy of the grid, hues, generation counter and size registers. For every
// accepted command it predicts the result, and it compares each returned
// result field by field. A directed opening covers the empty grid, a blinker
// that wraps at both edges, counter restart, the smallest grid and accesses
// outside it. Random phases follow under many register settings, with
// saturating sizes among them. Each phase seeds patterns, runs generations
// and reads cells back, mixed with noise. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module toroidal_life_grid_with_hue_age_core_test;
    import tlg_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    class life_scoreboard;
        bit live_q [CELLS];
        bit next_q [CELLS];
        logic [HUE_W-1:0] hue_q [CELLS];
        logic [HUE_W-1:0] gen_count;
        logic [HUE_W-1:0] base_hue;
        logic [CFG_ROWS_W-1:0] rows_reg;
        logic [CFG_COLS_W-1:0] cols_reg;
        res_t expected_q [$];
        int errors;

        function new();
            foreach (live_q[i])
            begin
                live_q[i] = 1'b0;
                next_q[i] = 1'b0;
                hue_q[i] = '0;
            end
            gen_count = '0;
            base_hue = '0;
            rows_reg = ROWS_RESET;
            cols_reg = COLS_RESET;
            errors = 0;
        endfunction

        function int eff_rows();
            int r;
            r = int'(rows_reg);
            if (r < MIN_DIM)
                r = MIN_DIM;
            if (r > MAX_ROWS)
                r = MAX_ROWS;
            return r;
        endfunction

        function int eff_cols();
            int c;
            c = int'(cols_reg);
            if (c < MIN_DIM)
                c = MIN_DIM;
            if (c > MAX_COLS)
                c = MAX_COLS;
            return c;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE_HUE: base_hue = data;
                CFG_ROWS_USED: rows_reg = data[CFG_ROWS_W-1:0];
                CFG_COLS_USED: cols_reg = data[CFG_COLS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_cmd(cmd_t c);
            res_t e;
            int nr, nc, r, cc, i, j, n, p, changed;
            int rws [3];
            int cls [3];
            logic [HUE_W-1:0] born;
            bit in_area;
            nr = eff_rows();
            nc = eff_cols();
            in_area = (int'(c.row) < nr) && (int'(c.col) < nc);
            p = int'(c.row) * MAX_COLS + int'(c.col);
            e = '0;
            case (c.func)
                FUNC_LOAD:
                begin
                    if (in_area)
                    begin
                        live_q[p] = c.alive_in;
                        hue_q[p] = base_hue;
                    end
                end
                FUNC_STEP:
                begin
                    born = base_hue + gen_count;
                    changed = 0;
                    for (r = 0; r < nr; r++)
                    begin
                        rws[0] = (r == 0) ? nr - 1 : r - 1;
                        rws[1] = r;
                        rws[2] = (r == nr - 1) ? 0 : r + 1;
                        for (cc = 0; cc < nc; cc++)
                        begin
                            cls[0] = (cc == 0) ? nc - 1 : cc - 1;
                            cls[1] = cc;
                            cls[2] = (cc == nc - 1) ? 0 : cc + 1;
                            p = r * MAX_COLS + cc;
                            n = 0;
                            for (i = 0; i < 3; i++)
                                for (j = 0; j < 3; j++)
                                    if (i != 1 || j != 1)
                                        n += int'(live_q[rws[i] * MAX_COLS + cls[j]]);
                            if (n == int'(BIRTH_COUNT))
                            begin
                                if (!live_q[p])
                                    hue_q[p] = born;
                                next_q[p] = 1'b1;
                            end
                            else if (n == int'(KEEP_COUNT))
                                next_q[p] = live_q[p];
                            else
                            begin
                                next_q[p] = 1'b0;
                                hue_q[p] = base_hue;
                            end
                            if (next_q[p] != live_q[p])
                                changed++;
                        end
                    end
                    for (r = 0; r < nr; r++)
                        for (cc = 0; cc < nc; cc++)
                            live_q[r * MAX_COLS + cc] = next_q[r * MAX_COLS + cc];
                    e.changed_count = CHG_W'((changed > 511) ? 511 : changed);
                    e.stable = (changed == 0);
                    gen_count = gen_count + 1'b1;
                end
                FUNC_READ:
                begin
                    if (in_area)
                    begin
                        e.alive_out = live_q[p];
                        e.hue_out = hue_q[p];
                    end
                end
                FUNC_RESTART: gen_count = base_hue;
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        function void mismatch(string field, int want, int got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_res(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result transaction with nothing expected");
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.alive_out !== want.alive_out)
                    mismatch("alive_out", int'(want.alive_out), int'(got.alive_out));
                if (got.hue_out !== want.hue_out)
                    mismatch("hue_out", int'(want.hue_out), int'(got.hue_out));
                if (got.changed_count !== want.changed_count)
                    mismatch("changed_count", int'(want.changed_count),
                             int'(got.changed_count));
                if (got.stable !== want.stable)
                    mismatch("stable", int'(want.stable), int'(got.stable));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    life_scoreboard book = new();
    bit cmd_idle_on = 1'b0;
    bit res_idle_on = 1'b0;
    int items_sent = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    toroidal_life_grid_with_hue_age_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // result side: random stalls, check every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            book.check_res(res);
        if (stall_left == 0 && res_idle_on && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        res_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("toroidal_life_grid_with_hue_age_core_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue(input logic [FUNC_W-1:0] f, input logic [IN_ROW_W-1:0] r,
                         input logic [IN_COL_W-1:0] c, input logic a);
        cmd_t item;
        int gap;
        item.func = f;
        item.row = r;
        item.col = c;
        item.alive_in = a;
        gap = (cmd_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        book.note_cmd(item);
        items_sent++;
    endtask

    task automatic finish_phase();
        cmd_valid <= 1'b0;
        while (book.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] hue_v,
                              input logic [CFG_DATA_W-1:0] rows_v,
                              input logic [CFG_DATA_W-1:0] cols_v);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int count;
        idx[0] = CFG_BASE_HUE;
        val[0] = hue_v;
        idx[1] = CFG_ROWS_USED;
        val[1] = rows_v;
        idx[2] = CFG_COLS_USED;
        val[2] = cols_v;
        idx[3] = CFG_SPARE;
        val[3] = CFG_DATA_W'($urandom);
        count = ($urandom_range(0, 3) == 0) ? 4 : 3;
        for (int i = 0; i < count; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            book.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // seed a pattern, maybe restart the counter, then run a few generations and peek at cells
    task automatic grow_pattern();
        repeat ($urandom_range(3, 16))
            issue(FUNC_LOAD, IN_ROW_W'($urandom_range(0, book.eff_rows() - 1)),
                  IN_COL_W'($urandom_range(0, book.eff_cols() - 1)),
                  $urandom_range(0, 9) < 7);
        if ($urandom_range(0, 9) == 0)
            issue(FUNC_RESTART, IN_ROW_W'($urandom), IN_COL_W'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 4))
        begin
            issue(FUNC_STEP, IN_ROW_W'($urandom), IN_COL_W'($urandom), 1'($urandom));
            repeat ($urandom_range(0, 3))
                issue(FUNC_READ, IN_ROW_W'($urandom_range(0, book.eff_rows() - 1)),
                      IN_COL_W'($urandom_range(0, book.eff_cols() - 1)), 1'($urandom));
        end
    endtask

    initial
    begin
        int phase;
        int sel;
        logic [CFG_DATA_W-1:0] hue_v;
        logic [3:0] rows_v;
        logic [5:0] cols_v;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size: empty grid, blinker across both wrap edges, restart
        issue(FUNC_READ, 0, 0, 1);
        issue(FUNC_STEP, 0, 0, 0);
        issue(FUNC_LOAD, 0, 31, 1);
        issue(FUNC_LOAD, 0, 0, 1);
        issue(FUNC_LOAD, 0, 1, 1);
        issue(FUNC_READ, 0, 31, 0);
        issue(FUNC_STEP, 7, 31, 1);
        issue(FUNC_READ, 7, 0, 0);
        issue(FUNC_READ, 1, 0, 1);
        issue(FUNC_READ, 0, 31, 0);
        issue(FUNC_RESTART, 7, 31, 1);
        issue(FUNC_LOAD, 7, 31, 1);
        issue(FUNC_LOAD, 7, 31, 0);
        issue(FUNC_STEP, 0, 0, 0);
        finish_phase();

        // smallest grid, top hue, accesses outside the used area
        cmd_idle_on = 1'b1;
        res_idle_on = 1'b1;
        set_config(8'hff, 8'h03, 8'h03);
        issue(FUNC_LOAD, 7, 31, 1);
        issue(FUNC_READ, 7, 31, 1);
        issue(FUNC_LOAD, 0, 0, 1);
        issue(FUNC_LOAD, 1, 1, 1);
        issue(FUNC_LOAD, 2, 2, 1);
        issue(FUNC_RESTART, 0, 0, 0);
        issue(FUNC_STEP, 0, 0, 0);
        issue(FUNC_READ, 1, 0, 0);
        issue(FUNC_READ, 2, 2, 0);
        issue(FUNC_STEP, 0, 0, 0);
        finish_phase();

        items_sent = 0;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            sel = (phase < 3) ? phase : $urandom_range(0, 5);
            case (sel)
                0:
                begin
                    hue_v = 8'h00;
                    rows_v = 4'd8;
                    cols_v = 6'd32;
                end
                1:
                begin
                    hue_v = 8'hff;
                    rows_v = 4'd3;
                    cols_v = 6'd3;
                end
                2:
                begin
                    hue_v = CFG_DATA_W'($urandom);
                    rows_v = $urandom_range(0, 1) ? 4'($urandom_range(0, 2))
                                                  : 4'($urandom_range(9, 15));
                    cols_v = $urandom_range(0, 1) ? 6'($urandom_range(0, 2))
                                                  : 6'($urandom_range(33, 63));
                end
                default:
                begin
                    hue_v = CFG_DATA_W'($urandom);
                    rows_v = 4'($urandom_range(3, 8));
                    cols_v = 6'($urandom_range(3, 32));
                end
            endcase
            set_config(hue_v, {4'($urandom), rows_v}, {2'($urandom), cols_v});
            cmd_idle_on = ($urandom_range(0, 3) != 0);
            res_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(5, 10))
            begin
                if (items_sent < ITEM_TARGET)
                begin
                    if ($urandom_range(0, 9) < 7)
                        grow_pattern();
                    else
                        repeat ($urandom_range(4, 10))
                            issue(FUNC_W'($urandom_range(0, 3)), IN_ROW_W'($urandom),
                                  IN_COL_W'($urandom), 1'($urandom));
                end
            end
            finish_phase();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.expected_q.size() == 0)
            $display("toroidal_life_grid_with_hue_age_core_test: PASS");
        else
            $display("toroidal_life_grid_with_hue_age_core_test: FAIL");
        $finish;
    end

endmodule
